>>> hw/rtl/gwdf_pkg.sv
package gwdf_pkg;

   // Defaults for the top-level parameters
   localparam int unsigned MAX_WIDTH_DEFAULT  = 128;
   localparam int unsigned MAX_HEIGHT_DEFAULT = 64;
   localparam int unsigned REACH_DEFAULT      = 10;

   // Field widths
   localparam int unsigned DIST_W     = 4;
   localparam int unsigned COL_W      = 7;
   localparam int unsigned ROW_W      = 6;
   localparam int unsigned METRIC_W   = 2;
   localparam int unsigned GW_W       = 8;
   localparam int unsigned GH_W       = 7;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 8;

   typedef logic [DIST_W-1:0]   dist_type;
   typedef logic [COL_W-1:0]    col_type;
   typedef logic [ROW_W-1:0]    row_type;
   typedef logic [METRIC_W-1:0] metric_type;
   typedef logic [GW_W-1:0]     gw_type;
   typedef logic [GH_W-1:0]     gh_type;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Metric codes; the unused code behaves as Euclidean
   localparam metric_type METRIC_EUCLID    = 2'd0;
   localparam metric_type METRIC_CHEBYSHEV = 2'd1;
   localparam metric_type METRIC_MANHATTAN = 2'd2;

   // Register indexes (word address bits)
   localparam logic [1:0] REG_METRIC      = 2'd0;
   localparam logic [1:0] REG_GRID_WIDTH  = 2'd1;
   localparam logic [1:0] REG_GRID_HEIGHT = 2'd2;

   localparam metric_type METRIC_RESET      = METRIC_EUCLID;
   localparam gw_type     GRID_WIDTH_RESET  = 8'd80;
   localparam gh_type     GRID_HEIGHT_RESET = 7'd45;

   // Tag that follows one window row down the scan pipeline
   typedef struct packed {
      logic     valid;
      logic     last;
      dist_type dy;
   } scan_tag_type;

   // Nearest blocked column of one window row
   typedef struct packed {
      scan_tag_type tag;
      logic         found;
      dist_type     dx;
   } probe_type;

endpackage

>>> hw/rtl/grid_wall_distance_field_top.sv
// Load item: taken when idle, writes one cell if it lies inside the grid, gives no result.
// Query inside the grid: each of the N window rows (N up to 2*REACH+1) passes the grid
//   memory read, row probe and running minimum registers before the result register.
// Query outside the grid: no scan; either way the next item waits for the result register.
// Query rate is set by the grid memory, read one window row per cycle.
// Reset: synchronous; a clearing pass over all MAX_HEIGHT rows zeroes the grid first.
module grid_wall_distance_field_top #(
   parameter int unsigned MAX_WIDTH  = gwdf_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_HEIGHT = gwdf_pkg::MAX_HEIGHT_DEFAULT,
   parameter int unsigned REACH      = gwdf_pkg::REACH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gwdf_pkg::REQ_DATA_W-1:0]    req_tdata,  // col[6:0], row[12:7], blocked[13]
   input  logic                               req_tuser,  // operation
   // Result items
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gwdf_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // distance[3:0]
   output logic                               rsp_tuser,  // out_of_range
   // Register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gwdf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gwdf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gwdf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // Configuration registers
   gwdf_pkg::metric_type   metric_ff, metric_in;
   gwdf_pkg::gw_type       grid_width_ff, grid_width_in;
   gwdf_pkg::gh_type       grid_height_ff, grid_height_in;
   logic                   csr_write;

   // Effective grid size, clipped to the storage
   gwdf_pkg::gw_type       w_eff;
   gwdf_pkg::gh_type       h_eff;

   // Unpacked input fields
   gwdf_pkg::col_type      req_col;
   gwdf_pkg::row_type      req_row;
   logic                   req_blocked;

   // Grid memory ports
   logic                   wr_en;
   logic                   wr_clear;
   logic [YW-1:0]          wr_row;
   logic [XW-1:0]          wr_col;
   logic                   wr_bit;
   logic                   rd_en;
   logic [YW-1:0]          rd_row;
   logic [MAX_WIDTH-1:0]   rd_data;

   // Scan pipeline
   gwdf_pkg::scan_tag_type scan_tag;
   gwdf_pkg::col_type      scan_col;
   gwdf_pkg::probe_type    probe;
   gwdf_pkg::dist_type     best;
   logic                   dist_start;
   gwdf_pkg::dist_type     rsp_distance;

   // Register writes complete in the access phase; the port never stalls
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      metric_in      = metric_ff;
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            gwdf_pkg::REG_METRIC: begin
               metric_in = csr_pwdata[gwdf_pkg::METRIC_W-1:0];
            end
            gwdf_pkg::REG_GRID_WIDTH: begin
               grid_width_in = csr_pwdata[gwdf_pkg::GW_W-1:0];
            end
            gwdf_pkg::REG_GRID_HEIGHT: begin
               grid_height_in = csr_pwdata[gwdf_pkg::GH_W-1:0];
            end
            default: begin
               // Drop writes to unmapped addresses
               metric_in = metric_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         gwdf_pkg::REG_METRIC: begin
            csr_prdata = gwdf_pkg::CSR_DATA_W'(metric_ff);
         end
         gwdf_pkg::REG_GRID_WIDTH: begin
            csr_prdata = gwdf_pkg::CSR_DATA_W'(grid_width_ff);
         end
         gwdf_pkg::REG_GRID_HEIGHT: begin
            csr_prdata = gwdf_pkg::CSR_DATA_W'(grid_height_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff      <= gwdf_pkg::METRIC_RESET;
         grid_width_ff  <= gwdf_pkg::GRID_WIDTH_RESET;
         grid_height_ff <= gwdf_pkg::GRID_HEIGHT_RESET;
      end else begin
         metric_ff      <= metric_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // A width or height beyond the storage acts as the storage size; zero means empty
   assign w_eff = (32'(grid_width_ff) > MAX_WIDTH) ? gwdf_pkg::gw_type'(MAX_WIDTH)
                                                   : grid_width_ff;
   assign h_eff = (32'(grid_height_ff) > MAX_HEIGHT) ? gwdf_pkg::gh_type'(MAX_HEIGHT)
                                                     : grid_height_ff;

   assign req_col     = req_tdata[6:0];
   assign req_row     = req_tdata[12:7];
   assign req_blocked = req_tdata[13];

   // Sequencer: clearing pass, loads, row scan of the query window, result register
   gwdf_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .REACH      (REACH)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_op           (req_tuser),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_blocked      (req_blocked),
      .w_eff            (w_eff),
      .h_eff            (h_eff),
      .wr_en            (wr_en),
      .wr_clear         (wr_clear),
      .wr_row           (wr_row),
      .wr_col           (wr_col),
      .wr_bit           (wr_bit),
      .rd_en            (rd_en),
      .rd_row           (rd_row),
      .scan_tag         (scan_tag),
      .scan_col         (scan_col),
      .probe            (probe),
      .best             (best),
      .dist_start       (dist_start),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_distance     (rsp_distance),
      .rsp_out_of_range (rsp_tuser)
   );

   // Occupancy grid, one row word per read
   gwdf_grid_mem #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_grid_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_clear (wr_clear),
      .wr_row   (wr_row),
      .wr_col   (wr_col),
      .wr_bit   (wr_bit),
      .rd_en    (rd_en),
      .rd_row   (rd_row),
      .rd_data  (rd_data)
   );

   // Nearest blocked column within the window for each row read
   gwdf_row_probe #(
      .MAX_WIDTH (MAX_WIDTH),
      .REACH     (REACH)
   ) u_row_probe (
      .clock    (clock),
      .reset    (reset),
      .row_data (rd_data),
      .tag      (scan_tag),
      .col      (scan_col),
      .w_eff    (w_eff),
      .probe    (probe)
   );

   // Shared metric unit; folds each row's distance into the running minimum
   gwdf_dist_unit #(
      .REACH (REACH)
   ) u_dist_unit (
      .clock  (clock),
      .start  (dist_start),
      .probe  (probe),
      .metric (metric_ff),
      .best   (best)
   );

   assign rsp_tdata = gwdf_pkg::RSP_DATA_W'(rsp_distance);

endmodule

>>> hw/rtl/gwdf_grid_mem.sv
module gwdf_grid_mem #(
   parameter int unsigned MAX_WIDTH  = gwdf_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_HEIGHT = gwdf_pkg::MAX_HEIGHT_DEFAULT,
   localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 wr_clear,
   input  logic [YW-1:0]        wr_row,
   input  logic [XW-1:0]        wr_col,
   input  logic                 wr_bit,
   input  logic                 rd_en,
   input  logic [YW-1:0]        rd_row,
   output logic [MAX_WIDTH-1:0] rd_data
);

   // One word per grid row, one bit per column
   logic [MAX_WIDTH-1:0] mem_ff [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_clear) begin
            mem_ff[wr_row] <= '0;
         end else begin
            mem_ff[wr_row][wr_col] <= wr_bit;
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/gwdf_row_probe.sv
module gwdf_row_probe #(
   parameter int unsigned MAX_WIDTH = gwdf_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned REACH     = gwdf_pkg::REACH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [MAX_WIDTH-1:0]    row_data,
   input  gwdf_pkg::scan_tag_type  tag,
   input  gwdf_pkg::col_type       col,
   input  gwdf_pkg::gw_type        w_eff,
   output gwdf_pkg::probe_type     probe
);

   localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned POS_W = (XW > 8) ? XW : 8;
   localparam int unsigned LANES = 2 * REACH + 1;

   logic [LANES-1:0]    lane;
   logic [REACH:0]      hit;
   logic [POS_W-1:0]    sum;
   logic [POS_W-1:0]    pos;
   gwdf_pkg::probe_type probe_in;
   gwdf_pkg::probe_type probe_ff;

   always_comb begin
      lane = '0;
      sum  = '0;
      pos  = '0;
      // Pick the window columns out of the row, dropping those off the grid
      for (int k = 0; k < int'(LANES); k++) begin
         sum = POS_W'(col) + POS_W'(k);
         pos = sum - POS_W'(REACH);
         if (sum >= POS_W'(REACH) && pos < POS_W'(w_eff)) begin
            lane[k] = row_data[pos[XW-1:0]];
         end
      end
      for (int d = 0; d <= int'(REACH); d++) begin
         hit[d] = lane[int'(REACH) - d] | lane[int'(REACH) + d];
      end
      probe_in.tag   = tag;
      probe_in.found = |hit;
      probe_in.dx    = '0;
      // Nearest hit wins
      for (int d = int'(REACH); d >= 0; d--) begin
         if (hit[d]) begin
            probe_in.dx = gwdf_pkg::dist_type'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign probe = probe_ff;

endmodule

>>> hw/rtl/gwdf_dist_unit.sv
module gwdf_dist_unit #(
   parameter int unsigned REACH = gwdf_pkg::REACH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  start,
   input  gwdf_pkg::probe_type   probe,
   input  gwdf_pkg::metric_type  metric,
   output gwdf_pkg::dist_type    best
);

   localparam int unsigned SQ_W  = 2 * gwdf_pkg::DIST_W + 1;
   localparam int unsigned MAN_W = gwdf_pkg::DIST_W + 1;

   logic [SQ_W-1:0]    dx_w;
   logic [SQ_W-1:0]    dy_w;
   logic [SQ_W-1:0]    sq;
   logic [MAN_W-1:0]   man;
   gwdf_pkg::dist_type eu;
   gwdf_pkg::dist_type cell_dist;
   gwdf_pkg::dist_type best_in;
   gwdf_pkg::dist_type best_ff;

   always_comb begin
      dx_w = SQ_W'(probe.dx);
      dy_w = SQ_W'(probe.tag.dy);
      sq   = dx_w * dx_w + dy_w * dy_w;
      // Smallest r with r*r >= dx*dx + dy*dy, saturated at the reach
      eu   = gwdf_pkg::dist_type'(REACH);
      for (int r = int'(REACH); r >= 0; r--) begin
         if (SQ_W'(r * r) >= sq) begin
            eu = gwdf_pkg::dist_type'(r);
         end
      end
      man = MAN_W'(probe.dx) + MAN_W'(probe.tag.dy);
      unique case (metric)
         gwdf_pkg::METRIC_CHEBYSHEV: begin
            cell_dist = (probe.dx > probe.tag.dy) ? probe.dx : probe.tag.dy;
         end
         gwdf_pkg::METRIC_MANHATTAN: begin
            cell_dist = (man > MAN_W'(REACH)) ? gwdf_pkg::dist_type'(REACH)
                                              : man[gwdf_pkg::DIST_W-1:0];
         end
         default: begin
            cell_dist = eu;
         end
      endcase
      if (cell_dist > gwdf_pkg::dist_type'(REACH)) begin
         cell_dist = gwdf_pkg::dist_type'(REACH);
      end

      best_in = best_ff;
      if (start) begin
         best_in = gwdf_pkg::dist_type'(REACH);
      end else if (probe.tag.valid && probe.found && cell_dist < best_ff) begin
         best_in = cell_dist;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign best = best_ff;

endmodule

>>> hw/rtl/gwdf_seq.sv
module gwdf_seq #(
   parameter int unsigned MAX_WIDTH  = gwdf_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_HEIGHT = gwdf_pkg::MAX_HEIGHT_DEFAULT,
   parameter int unsigned REACH      = gwdf_pkg::REACH_DEFAULT,
   localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  gwdf_pkg::col_type      req_col,
   input  gwdf_pkg::row_type      req_row,
   input  logic                   req_blocked,
   input  gwdf_pkg::gw_type       w_eff,
   input  gwdf_pkg::gh_type       h_eff,
   output logic                   wr_en,
   output logic                   wr_clear,
   output logic [YW-1:0]          wr_row,
   output logic [XW-1:0]          wr_col,
   output logic                   wr_bit,
   output logic                   rd_en,
   output logic [YW-1:0]          rd_row,
   output gwdf_pkg::scan_tag_type scan_tag,
   output gwdf_pkg::col_type      scan_col,
   input  gwdf_pkg::probe_type    probe,
   input  gwdf_pkg::dist_type     best,
   output logic                   dist_start,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gwdf_pkg::dist_type     rsp_distance,
   output logic                   rsp_out_of_range
);

   localparam int unsigned YCW   = (YW > 7) ? YW : 7;
   localparam int unsigned POS_W = (XW > 8) ? XW : 8;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [YW-1:0]          clr_ff, clr_in;
   gwdf_pkg::col_type      col_ff, col_in;
   gwdf_pkg::row_type      row_ff, row_in;
   logic [YCW-1:0]         y_ff, y_in;
   logic [YCW-1:0]         y_end_ff, y_end_in;
   logic                   oor_ff, oor_in;
   gwdf_pkg::scan_tag_type tag_ff, tag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   gwdf_pkg::dist_type     rsp_dist_ff, rsp_dist_in;
   logic                   rsp_oor_ff, rsp_oor_in;

   logic                   in_grid;
   logic [YCW-1:0]         row_ext;
   logic [POS_W-1:0]       col_ext;
   logic [YCW-1:0]         row_reach;
   logic [YCW-1:0]         h_last;
   logic [YCW-1:0]         y_first;
   logic [YCW-1:0]         y_last;
   logic [YCW-1:0]         row_ff_ext;
   logic [YCW-1:0]         dy_full;

   always_comb begin
      in_grid    = (gwdf_pkg::gw_type'(req_col) < w_eff) &&
                   (gwdf_pkg::gh_type'(req_row) < h_eff);
      row_ext    = YCW'(req_row);
      col_ext    = POS_W'(req_col);
      row_reach  = row_ext + YCW'(REACH);
      h_last     = YCW'(h_eff) - YCW'(1);
      y_first    = (row_ext > YCW'(REACH)) ? row_ext - YCW'(REACH) : '0;
      y_last     = (row_reach < h_last) ? row_reach : h_last;
      row_ff_ext = YCW'(row_ff);
      dy_full    = (y_ff >= row_ff_ext) ? y_ff - row_ff_ext : row_ff_ext - y_ff;

      state_in     = state_ff;
      clr_in       = clr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      y_in         = y_ff;
      y_end_in     = y_end_ff;
      oor_in       = oor_ff;
      tag_in       = '0;
      wr_en        = 1'b0;
      wr_clear     = 1'b0;
      wr_row       = row_ext[YW-1:0];
      wr_col       = col_ext[XW-1:0];
      wr_bit       = req_blocked;
      rd_en        = 1'b0;
      dist_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_oor_in   = rsp_oor_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_clear = 1'b1;
            wr_row   = clr_ff;
            clr_in   = clr_ff + YW'(1);
            if (clr_ff == YW'(MAX_HEIGHT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == gwdf_pkg::OP_LOAD) begin
                  wr_en = in_grid;
               end else if (in_grid) begin
                  col_in     = req_col;
                  row_in     = req_row;
                  y_in       = y_first;
                  y_end_in   = y_last;
                  oor_in     = 1'b0;
                  dist_start = 1'b1;
                  state_in   = ST_SCAN;
               end else begin
                  oor_in   = 1'b1;
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            rd_en        = 1'b1;
            tag_in.valid = 1'b1;
            tag_in.last  = (y_ff == y_end_ff);
            tag_in.dy    = dy_full[gwdf_pkg::DIST_W-1:0];
            y_in         = y_ff + YCW'(1);
            if (y_ff == y_end_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (probe.tag.valid && probe.tag.last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = oor_ff ? gwdf_pkg::dist_type'(REACH) : best;
               rsp_oor_in   = oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_row = y_ff[YW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      y_ff        <= y_in;
      y_end_ff    <= y_end_in;
      oor_ff      <= oor_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign scan_tag         = tag_ff;
   assign scan_col         = col_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance     = rsp_dist_ff;
   assign rsp_out_of_range = rsp_oor_ff;

`ifndef SYNTH
   a_tag_from_scan: assert property (@(posedge clock) disable iff (reset)
      tag_ff.valid |-> $past(state_ff == ST_SCAN))
      else $error("row tag without a scan cycle");

   a_no_write_in_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !wr_en)
      else $error("grid write while a query is in flight");

   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (y_ff <= y_end_ff))
      else $error("scan row past window end");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!tag_ff.valid && !probe.tag.valid))
      else $error("scan pipeline not empty in idle");
`endif

endmodule

>>> tb/grid_wall_distance_field_top_test.sv
module grid_wall_distance_field_top_test;

   localparam int MAX_COLS   = gwdf_pkg::MAX_WIDTH_DEFAULT;
   localparam int MAX_ROWS   = gwdf_pkg::MAX_HEIGHT_DEFAULT;
   localparam int REACH      = gwdf_pkg::REACH_DEFAULT;
   // Longest query is 2*REACH+1 window rows plus the scan pipeline registers
   localparam int QUIET_WAIT = 2 * REACH + 12;
   localparam int LONG_HOLD  = 250;
   localparam int STALL_MAX  = 2000;
   localparam int PHASE_ITEMS = 305;

   // The spare metric code has no name of its own; the block treats it as Euclidean
   localparam gwdf_pkg::metric_type METRIC_SPARE = 2'd3;

   typedef struct packed {
      gwdf_pkg::dist_type distance;
      logic               out_of_range;
   } wall_answer_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [gwdf_pkg::REQ_DATA_W-1:0] req_tdata;   // col[6:0], row[12:7], blocked[13]
   logic                            req_tuser;   // operation
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [gwdf_pkg::RSP_DATA_W-1:0] rsp_tdata;   // distance[3:0]
   logic                            rsp_tuser;   // out_of_range
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [gwdf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [gwdf_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [gwdf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // Shadow of the block: wall bits and register copies
   bit                   wall_bits [0:MAX_ROWS-1][0:MAX_COLS-1];
   gwdf_pkg::metric_type cfg_metric = gwdf_pkg::METRIC_RESET;
   gwdf_pkg::gw_type     cfg_width  = gwdf_pkg::GRID_WIDTH_RESET;
   gwdf_pkg::gh_type     cfg_height = gwdf_pkg::GRID_HEIGHT_RESET;

   wall_answer_type pending_answers[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles   = 0;

   int mismatch_count = 0;
   int load_count     = 0;
   int query_count    = 0;
   int answer_count   = 0;
   int setting_count  = 0;

   grid_wall_distance_field_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Oversized settings clamp to the physical grid
   function automatic int grid_cols();
      return (int'(cfg_width) > MAX_COLS) ? MAX_COLS : int'(cfg_width);
   endfunction

   function automatic int grid_rows();
      return (int'(cfg_height) > MAX_ROWS) ? MAX_ROWS : int'(cfg_height);
   endfunction

   // Distance for one offset under the current metric, saturated at REACH
   function automatic int metric_distance(int dx, int dy);
      int r;
      int s;
      case (cfg_metric)
         gwdf_pkg::METRIC_CHEBYSHEV: r = (dx > dy) ? dx : dy;
         gwdf_pkg::METRIC_MANHATTAN: r = dx + dy;
         default: begin
            // Euclidean rounded up: smallest r with r*r covering the squared length
            s = dx * dx + dy * dy;
            r = 0;
            while (r < REACH && r * r < s) r++;
         end
      endcase
      return (r > REACH) ? REACH : r;
   endfunction

   // Scan the clipped window around the cell and keep the nearest wall
   function automatic wall_answer_type nearest_wall(int c, int r);
      wall_answer_type answer;
      int w;
      int h;
      int best;
      int d;
      int x;
      int y;
      w = grid_cols();
      h = grid_rows();
      answer.out_of_range = 1'b0;
      if (c >= w || r >= h) begin
         answer.distance     = gwdf_pkg::dist_type'(REACH);
         answer.out_of_range = 1'b1;
         return answer;
      end
      best = REACH;
      for (y = (r > REACH) ? r - REACH : 0; y <= ((r + REACH < h - 1) ? r + REACH : h - 1);
           y++) begin
         for (x = (c > REACH) ? c - REACH : 0; x <= ((c + REACH < w - 1) ? c + REACH : w - 1);
              x++) begin
            if (wall_bits[y][x]) begin
               d = metric_distance((x > c) ? x - c : c - x, (y > r) ? y - r : r - y);
               if (d < best) best = d;
            end
         end
      end
      answer.distance = gwdf_pkg::dist_type'(best);
      return answer;
   endfunction

   // ---------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------

   // Offer one item, wait for its handshake, then update the shadow grid or
   // queue the answer it must produce. Enter and leave right after a rising edge.
   task automatic send_item(input logic op, input int c, input int r, input logic blocked);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, blocked, gwdf_pkg::row_type'(r), gwdf_pkg::col_type'(c)};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (op == gwdf_pkg::OP_LOAD) begin
         load_count++;
         // Loads outside the grid in use are dropped
         if (c < grid_cols() && r < grid_rows()) wall_bits[r][c] = blocked;
      end else begin
         query_count++;
         pending_answers.push_back(nearest_wall(c, r));
      end
   endtask

   // Drop valid and hold until every queued answer has come back
   task automatic drain_answers();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // One register write: setup cycle, then access cycle, then release the bus
   task automatic csr_write(input logic [1:0] reg_index,
                            input logic [gwdf_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= gwdf_pkg::CSR_ADDR_W'({reg_index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (reg_index)
         gwdf_pkg::REG_METRIC:      cfg_metric = gwdf_pkg::metric_type'(value);
         gwdf_pkg::REG_GRID_WIDTH:  cfg_width  = gwdf_pkg::gw_type'(value);
         gwdf_pkg::REG_GRID_HEIGHT: cfg_height = gwdf_pkg::gh_type'(value);
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Settle the block completely, then rewrite all three registers.
   // A trailing load gives no answer, so also wait out one full query time.
   task automatic apply_config(input gwdf_pkg::metric_type m, input int w, input int h);
      drain_answers();
      repeat (QUIET_WAIT) @(posedge clock);
      csr_write(gwdf_pkg::REG_METRIC, gwdf_pkg::CSR_DATA_W'(m));
      csr_write(gwdf_pkg::REG_GRID_WIDTH, gwdf_pkg::CSR_DATA_W'(w));
      csr_write(gwdf_pkg::REG_GRID_HEIGHT, gwdf_pkg::CSR_DATA_W'(h));
      setting_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset settings (Euclidean, 80 by 45): empty grid, one wall, the window
   // edge, the grid corner and a load that falls outside the grid
   task automatic test_default_grid();
      send_item(gwdf_pkg::OP_QUERY, 0, 0, 1'b1);     // no wall anywhere: full reach
      send_item(gwdf_pkg::OP_LOAD, 3, 4, 1'b1);
      send_item(gwdf_pkg::OP_QUERY, 0, 0, 1'b0);     // 3-4-5 triangle
      send_item(gwdf_pkg::OP_QUERY, 3, 4, 1'b0);     // on the wall itself
      send_item(gwdf_pkg::OP_QUERY, 13, 4, 1'b0);    // wall on the window edge
      send_item(gwdf_pkg::OP_LOAD, 127, 63, 1'b1);   // outside the grid: dropped
      send_item(gwdf_pkg::OP_QUERY, 127, 63, 1'b1);  // outside the grid: flagged
      send_item(gwdf_pkg::OP_LOAD, 79, 44, 1'b1);    // last cell of the grid
      send_item(gwdf_pkg::OP_QUERY, 72, 37, 1'b0);   // diagonal wall, distance rounds up to the reach
      send_item(gwdf_pkg::OP_LOAD, 0, 0, 1'b1);
      send_item(gwdf_pkg::OP_LOAD, 0, 0, 1'b0);      // clear it again
      send_item(gwdf_pkg::OP_QUERY, 0, 1, 1'b0);
   endtask

   // Every metric code against the same wall, the spare code included
   task automatic test_metric_codes();
      gwdf_pkg::metric_type codes[4];
      codes = '{gwdf_pkg::METRIC_CHEBYSHEV, gwdf_pkg::METRIC_MANHATTAN, METRIC_SPARE,
                gwdf_pkg::METRIC_EUCLID};
      foreach (codes[i]) begin
         apply_config(codes[i], gwdf_pkg::GRID_WIDTH_RESET, gwdf_pkg::GRID_HEIGHT_RESET);
         send_item(gwdf_pkg::OP_QUERY, 0, 0, 1'b0);
      end
   endtask

   // Empty, single-cell, full and oversized grids; stored bits survive resizing
   task automatic test_grid_extremes();
      apply_config(gwdf_pkg::METRIC_MANHATTAN, 0, 0);
      send_item(gwdf_pkg::OP_LOAD, 0, 0, 1'b1);      // empty grid: dropped
      send_item(gwdf_pkg::OP_QUERY, 0, 0, 1'b0);
      apply_config(gwdf_pkg::METRIC_EUCLID, 1, 1);
      send_item(gwdf_pkg::OP_QUERY, 0, 0, 1'b0);
      send_item(gwdf_pkg::OP_QUERY, 1, 0, 1'b0);
      apply_config(gwdf_pkg::METRIC_CHEBYSHEV, 255, 127);
      send_item(gwdf_pkg::OP_LOAD, 127, 63, 1'b1);
      send_item(gwdf_pkg::OP_QUERY, 120, 60, 1'b0);
      apply_config(gwdf_pkg::METRIC_EUCLID, 129, 65);
      send_item(gwdf_pkg::OP_QUERY, 127, 63, 1'b0);
      send_item(gwdf_pkg::OP_QUERY, 5, 6, 1'b0);     // the early wall is still there
   endtask

   // Random traffic under one random register setting. Loads and queries
   // cluster around a moving hot spot so the answers spread over the whole
   // distance range; a few items land anywhere in the field range.
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input bit hold_receiver, input bit pause_sender);
      int w;
      int h;
      int hot_c;
      int hot_r;
      int c;
      int r;
      int roll;
      logic op;
      logic blocked;
      case ($urandom_range(0, 9))
         0:       w = 1;
         1:       w = MAX_COLS;
         2:       w = $urandom_range(MAX_COLS + 1, 255);
         default: w = $urandom_range(12, MAX_COLS);
      endcase
      case ($urandom_range(0, 9))
         0:       h = 1;
         1:       h = MAX_ROWS;
         2:       h = $urandom_range(MAX_ROWS + 1, 127);
         default: h = $urandom_range(8, MAX_ROWS);
      endcase
      apply_config(gwdf_pkg::metric_type'($urandom_range(0, 3)), w, h);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      w = grid_cols();
      h = grid_rows();
      hot_c = $urandom_range(0, w - 1);
      hot_r = $urandom_range(0, h - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         // Stall the result side for a long stretch while items keep coming
         if (hold_receiver && n == PHASE_ITEMS / 3) hold_cycles <= LONG_HOLD;
         // Pause the sender until everything outstanding is answered
         if (pause_sender && n == PHASE_ITEMS / 2) drain_answers();
         roll    = $urandom_range(0, 99);
         blocked = 1'($urandom_range(0, 1));
         if (roll < 35) begin
            op = gwdf_pkg::OP_LOAD;
            blocked = ($urandom_range(0, 99) < 60);
            if (roll < 3) begin
               c = $urandom_range(0, 127);
               r = $urandom_range(0, 63);
            end else if (roll < 15) begin
               // Move the hot spot
               c = $urandom_range(0, w - 1);
               r = $urandom_range(0, h - 1);
               hot_c = c;
               hot_r = r;
            end else begin
               c = hot_c + $urandom_range(0, 12) - 6;
               r = hot_r + $urandom_range(0, 12) - 6;
               c = (c < 0) ? 0 : ((c > w - 1) ? w - 1 : c);
               r = (r < 0) ? 0 : ((r > h - 1) ? h - 1 : r);
            end
         end else begin
            op = gwdf_pkg::OP_QUERY;
            if (roll < 41) begin
               c = $urandom_range(0, 127);
               r = $urandom_range(0, 63);
            end else if (roll < 55) begin
               c = $urandom_range(0, w - 1);
               r = $urandom_range(0, h - 1);
            end else begin
               // Near the hot spot; wrap at the field width, may leave the grid
               c = (hot_c + $urandom_range(0, 24) - 12) & 127;
               r = (hot_r + $urandom_range(0, 24) - 12) & 63;
            end
         end
         send_item(op, c, r, blocked);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   // Receiver: a requested hold-off wins, otherwise stall at the phase's rate
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles != 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted result with the oldest queued answer
   always @(posedge clock) begin
      wall_answer_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         answer_count++;
         if (pending_answers.size() == 0) begin
            report_mismatch("result with no query pending, distance", int'(rsp_tdata[3:0]), 0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[gwdf_pkg::DIST_W-1:0] !== want.distance)
               report_mismatch("distance", int'(rsp_tdata[gwdf_pkg::DIST_W-1:0]),
                               int'(want.distance));
            if (rsp_tuser !== want.out_of_range)
               report_mismatch("out_of_range", int'(rsp_tuser), int'(want.out_of_range));
         end
      end
   end

   // Watchdog: end the run after a long stretch with no handshake at all
   initial begin : watchdog
      int stall;
      stall = 0;
      while (stall < STALL_MAX) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            stall = 0;
         else
            stall++;
      end
      $display("timeout: no handshake for %0d cycles", STALL_MAX);
      $display("grid_wall_distance_field_top_test: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin
      // Hold every input at a known value, then apply reset
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= gwdf_pkg::OP_LOAD;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The clearing pass after reset shows up as req_tready held low
      test_default_grid();
      test_metric_codes();
      test_grid_extremes();

      // Sender idles lightly, receiver heavily; the second phase adds a long hold-off
      test_random_traffic(6, 52, 1'b0, 1'b0);
      test_random_traffic(6, 52, 1'b1, 1'b0);
      // Swap the idle rates; the first of these pauses the sender midway
      test_random_traffic(52, 6, 1'b0, 1'b1);
      test_random_traffic(52, 6, 1'b0, 1'b0);
      // No idling on either side
      test_random_traffic(0, 0, 1'b0, 1'b0);
      test_random_traffic(0, 0, 1'b1, 1'b0);

      drain_answers();
      repeat (QUIET_WAIT) @(posedge clock);

      $display("covered %0d loads and %0d queries (%0d results checked) over %0d settings,",
               load_count, query_count, answer_count, setting_count);
      $display("all four metric codes, empty to oversized grids, with %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0)
         $display("grid_wall_distance_field_top_test: done, clean");
      else
         $display("grid_wall_distance_field_top_test: done, errors");
      $finish;
   end

endmodule
